// ===== rtl/x86_64_instruction_encoder_core_macros.svh =====
// Assertion helpers shared by the encoder modules.
`ifndef X86_64_INSTRUCTION_ENCODER_CORE_MACROS_SVH
`define X86_64_INSTRUCTION_ENCODER_CORE_MACROS_SVH

// Checked on every rising clock edge outside reset.
`define X86ENC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error(msg);

// Checked on every rising clock edge, reset included.
`define X86ENC_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== rtl/x86enc_pkg.sv =====
`default_nettype none

package x86enc_pkg;

    // Request modes.
    localparam logic [3:0] MODE_MOV64 = 4'd0;
    localparam logic [3:0] MODE_MOV32 = 4'd1;
    localparam logic [3:0] MODE_ADD64 = 4'd2;
    localparam logic [3:0] MODE_ADD32 = 4'd3;
    localparam logic [3:0] MODE_SUB64 = 4'd4;
    localparam logic [3:0] MODE_RET   = 4'd5;
    localparam logic [3:0] MODE_PUSH  = 4'd6;
    localparam logic [3:0] MODE_POP   = 4'd7;
    localparam logic [3:0] MODE_NOP   = 4'd8;
    localparam logic [3:0] MODE_CALL  = 4'd9;

    // Operand kinds.
    localparam logic [1:0] OPND_REG = 2'd0;
    localparam logic [1:0] OPND_IMM = 2'd1;
    localparam logic [1:0] OPND_MEM = 2'd2;

    // Opcodes.
    localparam logic [7:0] OP_MOV_IMM   = 8'hB8;
    localparam logic [7:0] OP_MOV_STORE = 8'h89;
    localparam logic [7:0] OP_MOV_LOAD  = 8'h8B;
    localparam logic [7:0] OP_ADD       = 8'h03;
    localparam logic [7:0] OP_SUB       = 8'h2B;
    localparam logic [7:0] OP_GRP1      = 8'h81;
    localparam logic [7:0] OP_PUSH      = 8'h50;
    localparam logic [7:0] OP_POP       = 8'h58;
    localparam logic [7:0] OP_RET       = 8'hC3;
    localparam logic [7:0] OP_NOP       = 8'h90;
    localparam logic [7:0] OP_GRP5      = 8'hFF;
    localparam logic [7:0] MODRM_CALL_RAX = 8'hD0;

    // Sizes.
    localparam int BUF_BYTES      = 11;
    localparam int CALL_BYTES     = 52;
    localparam int CALL_IMM_FIRST = 22;
    localparam int IDX_W          = $clog2(CALL_BYTES);
    localparam int QUEUE_DEPTH    = 4;
    localparam int QPTR_W         = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W         = QPTR_W + 1;

    typedef logic [BUF_BYTES-1:0][7:0] t_byte_buf;

    typedef enum logic [1:0] {
        K_CODE,
        K_CALL,
        K_ERROR
    } t_kind;

    // One classified instruction waiting to be emitted. For a call the
    // callee address sits in the low eight bytes.
    typedef struct packed {
        t_kind            kind;
        logic [IDX_W-1:0] count;
        t_byte_buf        bytes;
    } t_entry;

endpackage

`default_nettype wire

// ===== rtl/x86enc_if.sv =====
`default_nettype none

interface x86enc_req_if;
    logic        valid;
    logic        ready;
    logic [3:0]  mode;
    logic [1:0]  dst_kind;
    logic [3:0]  dst_reg;
    logic [31:0] dst_disp;
    logic [1:0]  src_kind;
    logic [3:0]  src_reg;
    logic [63:0] src_value;

    modport source(
        output valid, mode, dst_kind, dst_reg, dst_disp, src_kind, src_reg, src_value,
        input  ready
    );
    modport sink(
        input  valid, mode, dst_kind, dst_reg, dst_disp, src_kind, src_reg, src_value,
        output ready
    );
endinterface

interface x86enc_code_if;
    logic       valid;
    logic       ready;
    logic [7:0] code_byte;
    logic       last_byte;
    logic       bad_request;

    modport source(output valid, code_byte, last_byte, bad_request, input ready);
    modport sink(input valid, code_byte, last_byte, bad_request, output ready);
endinterface

`default_nettype wire

// ===== rtl/x86enc_front.sv =====
`default_nettype none

module x86enc_front (
    x86enc_req_if.sink          i_req,
    input  logic                i_full,
    output logic                o_push,
    output x86enc_pkg::t_entry  o_entry
);
    import x86enc_pkg::*;

    logic        w_bit;
    logic        dst_rm;
    logic        dst_mem;
    logic        src_mem;
    t_entry      ent;

    function automatic logic [7:0] rex(input logic w, input logic [3:0] r, input logic [3:0] b);
        return {4'h4, w, r[3], 1'b0, b[3]};
    endfunction

    function automatic logic [7:0] modrm(input logic mem, input logic [2:0] regf,
                                         input logic [2:0] rm);
        return {mem ? 2'b10 : 2'b11, regf, rm};
    endfunction

    assign w_bit   = (i_req.mode == MODE_MOV64) || (i_req.mode == MODE_ADD64)
                   || (i_req.mode == MODE_SUB64);
    assign dst_mem = (i_req.dst_kind == OPND_MEM);
    assign src_mem = (i_req.src_kind == OPND_MEM);
    assign dst_rm  = (i_req.dst_kind == OPND_REG) || dst_mem;

    always_comb begin
        ent.kind  = K_CODE;
        ent.count = '0;
        ent.bytes = '0;
        case (i_req.mode)
            MODE_MOV64, MODE_MOV32: begin
                if (i_req.dst_kind == OPND_REG && i_req.src_kind == OPND_IMM) begin
                    ent.bytes[0] = rex(w_bit, 4'd0, i_req.dst_reg);
                    ent.bytes[1] = OP_MOV_IMM + {5'd0, i_req.dst_reg[2:0]};
                    for (int i = 0; i < 8; i++) begin
                        ent.bytes[2+i] = i_req.src_value[8*i +: 8];
                    end
                    ent.count = w_bit ? IDX_W'(10) : IDX_W'(6);
                end else if (dst_rm && i_req.src_kind == OPND_REG) begin
                    // A move of a register onto itself produces no code at all.
                    if (!dst_mem && i_req.dst_reg == i_req.src_reg) begin
                        ent.count = '0;
                    end else begin
                        ent.bytes[0] = rex(w_bit, i_req.src_reg, i_req.dst_reg);
                        ent.bytes[1] = OP_MOV_STORE;
                        ent.bytes[2] = modrm(dst_mem, i_req.src_reg[2:0], i_req.dst_reg[2:0]);
                        for (int i = 0; i < 4; i++) begin
                            ent.bytes[3+i] = i_req.dst_disp[8*i +: 8];
                        end
                        ent.count = dst_mem ? IDX_W'(7) : IDX_W'(3);
                    end
                end else if (i_req.dst_kind == OPND_REG && src_mem) begin
                    ent.bytes[0] = rex(w_bit, i_req.dst_reg, i_req.src_reg);
                    ent.bytes[1] = OP_MOV_LOAD;
                    ent.bytes[2] = modrm(1'b1, i_req.dst_reg[2:0], i_req.src_reg[2:0]);
                    for (int i = 0; i < 4; i++) begin
                        ent.bytes[3+i] = i_req.src_value[8*i +: 8];
                    end
                    ent.count = IDX_W'(7);
                end else begin
                    ent.kind = K_ERROR;
                end
            end
            MODE_ADD64, MODE_ADD32: begin
                if (i_req.dst_kind == OPND_REG && i_req.src_kind == OPND_REG) begin
                    ent.bytes[0] = rex(w_bit, i_req.dst_reg, i_req.src_reg);
                    ent.bytes[1] = OP_ADD;
                    ent.bytes[2] = modrm(1'b0, i_req.dst_reg[2:0], i_req.src_reg[2:0]);
                    ent.count = IDX_W'(3);
                end else begin
                    ent.kind = K_ERROR;
                end
            end
            MODE_SUB64: begin
                if (i_req.dst_kind == OPND_REG && i_req.src_kind == OPND_REG) begin
                    ent.bytes[0] = rex(1'b1, i_req.dst_reg, i_req.src_reg);
                    ent.bytes[1] = OP_SUB;
                    ent.bytes[2] = modrm(1'b0, i_req.dst_reg[2:0], i_req.src_reg[2:0]);
                    ent.count = IDX_W'(3);
                end else if (dst_rm && i_req.src_kind == OPND_IMM
                             && i_req.src_value[63:32] == 32'd0) begin
                    ent.bytes[0] = rex(1'b1, 4'd0, i_req.dst_reg);
                    ent.bytes[1] = OP_GRP1;
                    ent.bytes[2] = modrm(dst_mem, 3'd5, i_req.dst_reg[2:0]);
                    if (dst_mem) begin
                        for (int i = 0; i < 4; i++) begin
                            ent.bytes[3+i] = i_req.dst_disp[8*i +: 8];
                            ent.bytes[7+i] = i_req.src_value[8*i +: 8];
                        end
                        ent.count = IDX_W'(11);
                    end else begin
                        for (int i = 0; i < 4; i++) begin
                            ent.bytes[3+i] = i_req.src_value[8*i +: 8];
                        end
                        ent.count = IDX_W'(7);
                    end
                end else begin
                    ent.kind = K_ERROR;
                end
            end
            MODE_RET: begin
                ent.bytes[0] = OP_RET;
                ent.count    = IDX_W'(1);
            end
            MODE_NOP: begin
                ent.bytes[0] = OP_NOP;
                ent.count    = IDX_W'(1);
            end
            MODE_PUSH, MODE_POP: begin
                if (i_req.dst_kind == OPND_REG) begin
                    ent.bytes[0] = rex(1'b1, 4'd0, i_req.dst_reg);
                    ent.bytes[1] = ((i_req.mode == MODE_PUSH) ? OP_PUSH : OP_POP)
                                 + {5'd0, i_req.dst_reg[2:0]};
                    ent.count = IDX_W'(2);
                end else begin
                    ent.kind = K_ERROR;
                end
            end
            MODE_CALL: begin
                ent.kind = K_CALL;
                for (int i = 0; i < 8; i++) begin
                    ent.bytes[i] = i_req.src_value[8*i +: 8];
                end
                ent.count = IDX_W'(CALL_BYTES);
            end
            default: begin
                ent.kind = K_ERROR;
            end
        endcase
        // The error transaction is a single zero byte.
        if (ent.kind == K_ERROR) begin
            ent.bytes = '0;
            ent.count = IDX_W'(1);
        end
    end

    assign i_req.ready = !i_full;
    assign o_push      = i_req.valid && !i_full && (ent.count != '0);
    assign o_entry     = ent;

endmodule

`default_nettype wire

// ===== rtl/x86enc_queue.sv =====
`default_nettype none
`include "x86_64_instruction_encoder_core_macros.svh"

module x86enc_queue (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    input  x86enc_pkg::t_entry i_entry,
    output logic               o_full,
    output logic               o_valid,
    output x86enc_pkg::t_entry o_entry,
    input  logic               i_pop
);
    import x86enc_pkg::*;

    t_entry              r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                do_pop;

    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (!i_push && do_pop) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    `X86ENC_ASSERT(a_no_push_full, i_clk, i_rst_n, !(i_push && o_full), "push into a full queue")
    `X86ENC_ASSERT(a_count_bound, i_clk, i_rst_n, r_count <= QCNT_W'(QUEUE_DEPTH), "queue count overflow")
    `X86ENC_ASSERT(a_ptr_gap, i_clk, i_rst_n, (r_wr_ptr - r_rd_ptr) == r_count[QPTR_W-1:0], "queue pointers disagree with count")
    `X86ENC_ASSERT_ALWAYS(a_reset_empty, i_clk, !i_rst_n |=> r_count == '0, "queue not empty after reset")

endmodule

`default_nettype wire

// ===== rtl/x86enc_back.sv =====
`default_nettype none
`include "x86_64_instruction_encoder_core_macros.svh"

module x86enc_back (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  x86enc_pkg::t_entry i_entry,
    output logic               o_pop,
    x86enc_code_if.source      o_code
);
    import x86enc_pkg::*;

    // Caller-saved register wrapper around "call rax". The callee address
    // is spliced into the eight bytes after 48 B8.
    localparam logic [7:0] CALL_SEQ [CALL_BYTES] = '{
        8'h48, 8'h51, 8'h48, 8'h52, 8'h48, 8'h56, 8'h48, 8'h57,
        8'h49, 8'h50, 8'h49, 8'h51, 8'h49, 8'h52, 8'h49, 8'h53,
        8'h48, 8'h83, 8'hEC, 8'h08,
        8'h48, OP_MOV_IMM,
        8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00,
        OP_GRP5, MODRM_CALL_RAX,
        8'h48, 8'h83, 8'hC4, 8'h08,
        8'h49, 8'h5B, 8'h49, 8'h5A, 8'h49, 8'h59, 8'h49, 8'h58,
        8'h48, 8'h5F, 8'h48, 8'h5E, 8'h48, 8'h5A, 8'h48, 8'h59
    };

    logic [IDX_W-1:0] r_idx;
    logic             r_out_valid;
    logic [7:0]       r_out_byte;
    logic             r_out_last;
    logic             r_out_bad;
    logic             emit;
    logic             last;
    logic [2:0]       imm_sel;
    logic             in_imm;
    logic [7:0]       n_byte;

    assign emit    = i_valid && (!r_out_valid || o_code.ready);
    assign last    = (r_idx == i_entry.count - IDX_W'(1));
    assign in_imm  = (r_idx >= IDX_W'(CALL_IMM_FIRST)) && (r_idx < IDX_W'(CALL_IMM_FIRST + 8));
    assign imm_sel = 3'(r_idx - IDX_W'(CALL_IMM_FIRST));

    always_comb begin
        case (i_entry.kind)
            K_CODE:  n_byte = i_entry.bytes[r_idx[3:0]];
            K_CALL:  n_byte = in_imm ? i_entry.bytes[{1'b0, imm_sel}] : CALL_SEQ[r_idx];
            default: n_byte = 8'h00;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (emit) begin
                r_idx       <= last ? '0 : r_idx + IDX_W'(1);
                r_out_valid <= 1'b1;
            end else if (o_code.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_byte <= n_byte;
            r_out_last <= last;
            r_out_bad  <= (i_entry.kind == K_ERROR);
        end
    end

    assign o_pop              = emit && last;
    assign o_code.valid       = r_out_valid;
    assign o_code.code_byte   = r_out_byte;
    assign o_code.last_byte   = r_out_last;
    assign o_code.bad_request = r_out_bad;

    `X86ENC_ASSERT(a_idx_in_range, i_clk, i_rst_n, i_valid |-> r_idx < i_entry.count, "byte index past instruction length")
    `X86ENC_ASSERT(a_err_is_last, i_clk, i_rst_n, (r_out_valid && r_out_bad) |-> r_out_last, "error transaction not marked last")
    `X86ENC_ASSERT(a_idx_wraps, i_clk, i_rst_n, (emit && last) |=> r_idx == '0, "index not cleared after last byte")

endmodule

`default_nettype wire

// ===== rtl/x86_64_instruction_encoder_core.sv =====
// x86-64 instruction encoder. Each request transaction on i_req names an
// operation and two operands; the block answers with the machine code bytes
// on o_code, one byte per transaction, little-endian, with last_byte on the
// final one. An unsupported request answers with a single transaction that
// has bad_request and last_byte set. A move of a register onto itself is
// accepted and produces no transactions. The front end classifies a request
// in the cycle it is accepted and places it in a four-entry queue; the back
// end emits one byte per cycle from the queue head through an output
// register while o_code is not stalled. Ordinary instructions have 1 to 11
// bytes, the call wrapper 52. Requests are taken one per cycle as long as
// the queue has room.
`default_nettype none

module x86_64_instruction_encoder_core (
    input  logic           i_clk,
    input  logic           i_rst_n,
    x86enc_req_if.sink     i_req,
    x86enc_code_if.source  o_code
);
    import x86enc_pkg::*;

    logic   q_push;
    logic   q_full;
    logic   q_valid;
    logic   q_pop;
    t_entry front_entry;
    t_entry head_entry;

    x86enc_front u_front (
        .i_req   (i_req),
        .i_full  (q_full),
        .o_push  (q_push),
        .o_entry (front_entry)
    );

    x86enc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_entry (front_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .o_entry (head_entry),
        .i_pop   (q_pop)
    );

    x86enc_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_entry (head_entry),
        .o_pop   (q_pop),
        .o_code  (o_code)
    );

endmodule

`default_nettype wire

// ===== tb/x86_64_instruction_encoder_core_tb.sv =====
`default_nettype none

module x86_64_instruction_encoder_core_tb;
    import x86enc_pkg::*;

    localparam int NUM_DIRECTED = 26;
    localparam int NUM_RANDOM   = 174;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 120;
    localparam int PRINT_CAP    = 30;

    // Codes outside the supported set.
    localparam logic [3:0] MODE_FIRST_UNUSED = 4'd10;
    localparam logic [3:0] MODE_LAST_UNUSED  = 4'd15;
    localparam logic [1:0] OPND_BAD          = 2'd3;

    localparam logic [3:0] REG_RAX = 4'd0;
    localparam logic [3:0] REG_RBX = 4'd3;
    localparam logic [3:0] REG_RSP = 4'd4;
    localparam logic [3:0] REG_R8  = 4'd8;
    localparam logic [3:0] REG_R9  = 4'd9;
    localparam logic [3:0] REG_R12 = 4'd12;
    localparam logic [3:0] REG_R13 = 4'd13;
    localparam logic [3:0] REG_R15 = 4'd15;

    // Stack adjustment around the wrapped call: 83 /5 ib and 83 /0 ib on RSP.
    localparam logic [7:0] OP_GRP1_IMM8  = 8'h83;
    localparam logic [7:0] MODRM_SUB_RSP = 8'hEC;
    localparam logic [7:0] MODRM_ADD_RSP = 8'hC4;
    localparam logic [7:0] STACK_PAD     = 8'h08;
    localparam logic [2:0] GRP1_SUB_EXT  = 3'd5;
    // RCX, RDX, RSI, RDI, R8..R11, pushed in this order.
    localparam logic [31:0] CALLER_SAVED = {4'd11, 4'd10, 4'd9, 4'd8,
                                            4'd7, 4'd6, 4'd2, 4'd1};

    typedef logic [7:0] t_byte_q[$];

    typedef struct {
        logic [3:0]  mode;
        logic [1:0]  dst_kind;
        logic [3:0]  dst_reg;
        logic [31:0] dst_disp;
        logic [1:0]  src_kind;
        logic [3:0]  src_reg;
        logic [63:0] src_value;
    } t_enc_req;

    typedef struct {
        t_enc_req    req;
        int          typed_len;   // -1 when the bytes come from the encoder model
        logic [15:0] typed_code;  // first byte in the upper half
        logic        typed_bad;
    } t_stim_row;

    typedef struct {
        logic [7:0] code;
        logic       last;
        logic       bad;
    } t_code_beat;

    logic clk = 1'b0;
    logic rst_n;

    x86enc_req_if  req_ch();
    x86enc_code_if code_ch();

    x86_64_instruction_encoder_core dut (
        .i_clk  (clk),
        .i_rst_n(rst_n),
        .i_req  (req_ch),
        .o_code (code_ch)
    );

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    t_code_beat pending_bytes[$];
    t_code_beat want;
    t_stim_row  directed_rows[NUM_DIRECTED];
    int cycle_count  = 0;
    int n_mismatches = 0;
    int n_requests   = 0;
    int n_calls      = 0;
    int n_bytes      = 0;
    int n_rejected   = 0;
    int seg_left     = 0;
    int stall_style  = 0;
    int stall_phase  = 0;

    function automatic logic [7:0] rex_byte(input bit w, input logic [3:0] r,
                                            input logic [3:0] b);
        return {4'b0100, w, r[3], 1'b0, b[3]};
    endfunction

    function automatic t_byte_q le_bytes(input logic [63:0] v, input int n);
        t_byte_q q;
        for (int i = 0; i < n; i++)
            q = {q, v[8*i +: 8]};
        return q;
    endfunction

    function automatic t_byte_q modrm_bytes(input logic [1:0] kind, input logic [3:0] base,
                                            input logic [31:0] disp,
                                            input logic [2:0] regfield);
        t_byte_q q;
        logic [7:0] m;
        m = {(kind == OPND_REG) ? 2'b11 : 2'b10, regfield, base[2:0]};
        q = {m};
        if (kind == OPND_MEM)
            q = {q, le_bytes({32'd0, disp}, 4)};
        return q;
    endfunction

    // Machine code for one request; returns 0 when the request is rejected.
    function automatic bit encode_request(input t_enc_req r, output t_byte_q code);
        bit w;
        bit dst_rm;
        logic [3:0] saved;
        code = {};
        w = (r.mode != MODE_MOV32) && (r.mode != MODE_ADD32);
        dst_rm = (r.dst_kind == OPND_REG) || (r.dst_kind == OPND_MEM);
        case (r.mode)
            MODE_MOV64, MODE_MOV32: begin
                if (r.dst_kind == OPND_REG && r.src_kind == OPND_IMM) begin
                    code = {rex_byte(w, REG_RAX, r.dst_reg),
                            8'(OP_MOV_IMM + r.dst_reg[2:0]),
                            le_bytes(r.src_value, w ? 8 : 4)};
                end else if (dst_rm && r.src_kind == OPND_REG) begin
                    // A register copied onto itself needs no code at all.
                    if (!(r.dst_kind == OPND_REG && r.dst_reg == r.src_reg))
                        code = {rex_byte(w, r.src_reg, r.dst_reg), OP_MOV_STORE,
                                modrm_bytes(r.dst_kind, r.dst_reg, r.dst_disp,
                                            r.src_reg[2:0])};
                end else if (r.dst_kind == OPND_REG && r.src_kind == OPND_MEM) begin
                    code = {rex_byte(w, r.dst_reg, r.src_reg), OP_MOV_LOAD,
                            modrm_bytes(r.src_kind, r.src_reg, r.src_value[31:0],
                                        r.dst_reg[2:0])};
                end else begin
                    return 1'b0;
                end
            end
            MODE_ADD64, MODE_ADD32: begin
                if (r.dst_kind != OPND_REG || r.src_kind != OPND_REG)
                    return 1'b0;
                code = {rex_byte(w, r.dst_reg, r.src_reg), OP_ADD,
                        modrm_bytes(OPND_REG, r.src_reg, 32'd0, r.dst_reg[2:0])};
            end
            MODE_SUB64: begin
                if (r.dst_kind == OPND_REG && r.src_kind == OPND_REG) begin
                    code = {rex_byte(1'b1, r.dst_reg, r.src_reg), OP_SUB,
                            modrm_bytes(OPND_REG, r.src_reg, 32'd0, r.dst_reg[2:0])};
                end else if (dst_rm && r.src_kind == OPND_IMM
                             && r.src_value[63:32] == 32'd0) begin
                    code = {rex_byte(1'b1, REG_RAX, r.dst_reg), OP_GRP1,
                            modrm_bytes(r.dst_kind, r.dst_reg, r.dst_disp, GRP1_SUB_EXT),
                            le_bytes(r.src_value, 4)};
                end else begin
                    return 1'b0;
                end
            end
            MODE_RET: code = {OP_RET};
            MODE_NOP: code = {OP_NOP};
            MODE_PUSH, MODE_POP: begin
                if (r.dst_kind != OPND_REG)
                    return 1'b0;
                code = {rex_byte(1'b1, REG_RAX, r.dst_reg),
                        8'(((r.mode == MODE_PUSH) ? OP_PUSH : OP_POP) + r.dst_reg[2:0])};
            end
            MODE_CALL: begin
                for (int i = 0; i < 8; i++) begin
                    saved = CALLER_SAVED[4*i +: 4];
                    code = {code, rex_byte(1'b1, REG_RAX, saved), 8'(OP_PUSH + saved[2:0])};
                end
                code = {code, rex_byte(1'b1, REG_RAX, REG_RAX), OP_GRP1_IMM8,
                        MODRM_SUB_RSP, STACK_PAD,
                        rex_byte(1'b1, REG_RAX, REG_RAX), OP_MOV_IMM,
                        le_bytes(r.src_value, 8), OP_GRP5, MODRM_CALL_RAX,
                        rex_byte(1'b1, REG_RAX, REG_RAX), OP_GRP1_IMM8,
                        MODRM_ADD_RSP, STACK_PAD};
                for (int i = 7; i >= 0; i--) begin
                    saved = CALLER_SAVED[4*i +: 4];
                    code = {code, rex_byte(1'b1, REG_RAX, saved), 8'(OP_POP + saved[2:0])};
                end
            end
            default: return 1'b0;
        endcase
        return 1'b1;
    endfunction

    function automatic t_stim_row mk_row(input logic [3:0] mode, input logic [1:0] dk,
                                         input logic [3:0] dr, input logic [31:0] dd,
                                         input logic [1:0] sk, input logic [3:0] sr,
                                         input logic [63:0] sv, input int len,
                                         input logic [15:0] code, input logic bad);
        t_stim_row row;
        row.req = '{mode, dk, dr, dd, sk, sr, sv};
        row.typed_len = len;
        row.typed_code = code;
        row.typed_bad = bad;
        return row;
    endfunction

    // Mostly well-formed operand pairings for the chosen operation, with some noise.
    function automatic t_stim_row random_row();
        t_stim_row row;
        int roll;
        row.typed_len = -1;
        row.typed_code = '0;
        row.typed_bad = 1'b0;
        row.req.dst_reg = 4'($urandom_range(0, 15));
        row.req.src_reg = 4'($urandom_range(0, 15));
        row.req.dst_disp = $urandom;
        row.req.src_value = {$urandom, $urandom};
        row.req.dst_kind = 2'($urandom_range(0, 3));
        row.req.src_kind = 2'($urandom_range(0, 3));
        roll = $urandom_range(0, 99);
        if (roll < 4)
            row.req.mode = 4'($urandom_range(MODE_FIRST_UNUSED, MODE_LAST_UNUSED));
        else if (roll < 9)
            row.req.mode = MODE_CALL;
        else
            row.req.mode = 4'($urandom_range(MODE_MOV64, MODE_NOP));
        if ($urandom_range(0, 9) != 0) begin
            case (row.req.mode)
                MODE_MOV64, MODE_MOV32: begin
                    case ($urandom_range(0, 3))
                        0: begin row.req.dst_kind = OPND_REG; row.req.src_kind = OPND_IMM; end
                        1: begin row.req.dst_kind = OPND_REG; row.req.src_kind = OPND_REG; end
                        2: begin row.req.dst_kind = OPND_MEM; row.req.src_kind = OPND_REG; end
                        default: begin
                            row.req.dst_kind = OPND_REG;
                            row.req.src_kind = OPND_MEM;
                        end
                    endcase
                    if (row.req.src_kind == OPND_REG && row.req.dst_kind == OPND_REG
                        && $urandom_range(0, 5) == 0)
                        row.req.src_reg = row.req.dst_reg;
                end
                MODE_ADD64, MODE_ADD32: begin
                    row.req.dst_kind = OPND_REG;
                    row.req.src_kind = OPND_REG;
                end
                MODE_SUB64: begin
                    case ($urandom_range(0, 2))
                        0: begin row.req.dst_kind = OPND_REG; row.req.src_kind = OPND_REG; end
                        1: begin row.req.dst_kind = OPND_REG; row.req.src_kind = OPND_IMM; end
                        default: begin
                            row.req.dst_kind = OPND_MEM;
                            row.req.src_kind = OPND_IMM;
                        end
                    endcase
                    if ($urandom_range(0, 3) != 0)
                        row.req.src_value[63:32] = '0;
                end
                MODE_PUSH, MODE_POP: row.req.dst_kind = OPND_REG;
                default: ;
            endcase
        end
        return row;
    endfunction

    task automatic report_mismatch(input string what);
        n_mismatches++;
        if (n_mismatches <= PRINT_CAP)
            $display("MISMATCH cycle %0d: %s", cycle_count, what);
    endtask

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out with %0d code bytes outstanding.", pending_bytes.size());
            $display("simulation failed");
            $finish;
        end
    end

    // The output side stalls in segments, each with its own stall style.
    always @(negedge clk) begin
        if (seg_left == 0) begin
            seg_left = $urandom_range(8, 60);
            stall_style = $urandom_range(0, 3);
        end
        seg_left--;
        stall_phase++;
        case (stall_style)
            0: code_ch.ready = 1'b1;
            1: code_ch.ready = 1'($urandom_range(0, 1));
            2: code_ch.ready = (stall_phase % 3 == 0);
            default: code_ch.ready = ($urandom_range(0, 7) != 0);
        endcase
    end

    always @(posedge clk) begin
        if (rst_n === 1'b1 && code_ch.valid === 1'b1 && code_ch.ready === 1'b1) begin
            n_bytes++;
            if (code_ch.bad_request === 1'b1)
                n_rejected++;
            if (pending_bytes.size() == 0) begin
                report_mismatch($sformatf("code byte %02h arrived with nothing expected",
                                          code_ch.code_byte));
            end else begin
                want = pending_bytes.pop_front();
                if (code_ch.code_byte !== want.code)
                    report_mismatch($sformatf("code_byte %02h, expected %02h",
                                              code_ch.code_byte, want.code));
                if (code_ch.last_byte !== want.last)
                    report_mismatch($sformatf("last_byte %b, expected %b",
                                              code_ch.last_byte, want.last));
                if (code_ch.bad_request !== want.bad)
                    report_mismatch($sformatf("bad_request %b, expected %b",
                                              code_ch.bad_request, want.bad));
            end
        end
    end

    initial begin
        t_stim_row  row;
        t_byte_q    code;
        t_code_beat beat;
        int burst_left;
        int gap;

        rst_n = 1'b0;
        req_ch.valid = 1'b0;
        req_ch.mode = MODE_NOP;
        req_ch.dst_kind = OPND_REG;
        req_ch.dst_reg = REG_RAX;
        req_ch.dst_disp = '0;
        req_ch.src_kind = OPND_REG;
        req_ch.src_reg = REG_RAX;
        req_ch.src_value = '0;
        burst_left = 0;

        directed_rows[0]  = mk_row(MODE_RET, OPND_REG, REG_RAX, '0, OPND_REG, REG_RAX, '0,
                                   1, {OP_RET, 8'h00}, 1'b0);
        directed_rows[1]  = mk_row(MODE_NOP, OPND_BAD, REG_R15, '1, OPND_BAD, REG_R15, '1,
                                   1, {OP_NOP, 8'h00}, 1'b0);
        directed_rows[2]  = mk_row(MODE_LAST_UNUSED, OPND_REG, REG_RAX, '0, OPND_REG,
                                   REG_RAX, '0, 1, 16'h0000, 1'b1);
        directed_rows[3]  = mk_row(MODE_FIRST_UNUSED, OPND_BAD, REG_R15, '1, OPND_BAD,
                                   REG_R15, '1, 1, 16'h0000, 1'b1);
        directed_rows[4]  = mk_row(MODE_MOV64, OPND_REG, REG_RAX, '0, OPND_IMM, REG_RAX, '1,
                                   -1, '0, 1'b0);
        directed_rows[5]  = mk_row(MODE_MOV32, OPND_REG, REG_R15, '1, OPND_IMM, REG_R15, '0,
                                   -1, '0, 1'b0);
        // A register moved onto itself produces nothing.
        directed_rows[6]  = mk_row(MODE_MOV64, OPND_REG, REG_R9, '0, OPND_REG, REG_R9, '0,
                                   0, '0, 1'b0);
        directed_rows[7]  = mk_row(MODE_MOV64, OPND_MEM, REG_R12, '1, OPND_REG, REG_R15, '0,
                                   -1, '0, 1'b0);
        directed_rows[8]  = mk_row(MODE_MOV32, OPND_MEM, REG_RSP, '0, OPND_REG, REG_RAX, '1,
                                   -1, '0, 1'b0);
        directed_rows[9]  = mk_row(MODE_MOV64, OPND_REG, REG_R15, '0, OPND_MEM, REG_R13,
                                   64'hFFFF_FFFF_8000_0001, -1, '0, 1'b0);
        directed_rows[10] = mk_row(MODE_MOV64, OPND_IMM, REG_RAX, '0, OPND_REG, REG_RBX, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[11] = mk_row(MODE_MOV32, OPND_MEM, REG_RBX, '0, OPND_IMM, REG_RAX, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[12] = mk_row(MODE_MOV64, OPND_MEM, REG_RBX, '0, OPND_MEM, REG_R8, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[13] = mk_row(MODE_ADD64, OPND_REG, REG_R15, '0, OPND_REG, REG_R8, '0,
                                   -1, '0, 1'b0);
        directed_rows[14] = mk_row(MODE_ADD32, OPND_REG, REG_RAX, '0, OPND_REG, REG_RAX, '0,
                                   -1, '0, 1'b0);
        directed_rows[15] = mk_row(MODE_ADD64, OPND_REG, REG_RAX, '0, OPND_MEM, REG_RBX, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[16] = mk_row(MODE_SUB64, OPND_REG, REG_R15, '0, OPND_REG, REG_RAX, '0,
                                   -1, '0, 1'b0);
        directed_rows[17] = mk_row(MODE_SUB64, OPND_MEM, REG_RSP, '1, OPND_IMM, REG_RAX,
                                   64'h0000_0000_FFFF_FFFF, -1, '0, 1'b0);
        // One past the widest sub immediate is rejected.
        directed_rows[18] = mk_row(MODE_SUB64, OPND_REG, REG_RAX, '0, OPND_IMM, REG_RAX,
                                   64'h0000_0001_0000_0000, 1, 16'h0000, 1'b1);
        directed_rows[19] = mk_row(MODE_SUB64, OPND_REG, REG_R8, '0, OPND_MEM, REG_R9, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[20] = mk_row(MODE_PUSH, OPND_REG, REG_R15, '0, OPND_BAD, REG_RAX, '1,
                                   2, 16'h4957, 1'b0);
        directed_rows[21] = mk_row(MODE_POP, OPND_REG, REG_RAX, '0, OPND_IMM, REG_R15, '0,
                                   2, 16'h4858, 1'b0);
        directed_rows[22] = mk_row(MODE_PUSH, OPND_MEM, REG_RAX, '0, OPND_REG, REG_RAX, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[23] = mk_row(MODE_POP, OPND_BAD, REG_RAX, '0, OPND_REG, REG_RAX, '0,
                                   1, 16'h0000, 1'b1);
        directed_rows[24] = mk_row(MODE_CALL, OPND_BAD, REG_R15, '1, OPND_MEM, REG_R15,
                                   64'h0123_4567_89AB_CDEF, -1, '0, 1'b0);
        directed_rows[25] = mk_row(MODE_MOV64, OPND_REG, REG_RAX, '0, OPND_BAD, REG_RBX, '0,
                                   1, 16'h0000, 1'b1);

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        for (int idx = 0; idx < NUM_DIRECTED + NUM_RANDOM; idx++) begin
            // Requests come in bursts separated by idle gaps of random length.
            if (burst_left == 0) begin
                gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    req_ch.valid = 1'b0;
                    repeat (gap) @(negedge clk);
                end
                burst_left = $urandom_range(1, 16);
            end
            row = (idx < NUM_DIRECTED) ? directed_rows[idx] : random_row();
            req_ch.mode = row.req.mode;
            req_ch.dst_kind = row.req.dst_kind;
            req_ch.dst_reg = row.req.dst_reg;
            req_ch.dst_disp = row.req.dst_disp;
            req_ch.src_kind = row.req.src_kind;
            req_ch.src_reg = row.req.src_reg;
            req_ch.src_value = row.req.src_value;
            req_ch.valid = 1'b1;
            @(posedge clk);
            while (req_ch.ready !== 1'b1)
                @(posedge clk);

            n_requests++;
            if (row.req.mode == MODE_CALL)
                n_calls++;
            if (row.typed_len >= 0) begin
                for (int i = 0; i < row.typed_len; i++) begin
                    beat.code = row.typed_code[15 - 8*i -: 8];
                    beat.last = (i == row.typed_len - 1);
                    beat.bad = row.typed_bad;
                    pending_bytes = {pending_bytes, beat};
                end
            end else if (encode_request(row.req, code)) begin
                foreach (code[i]) begin
                    beat.code = code[i];
                    beat.last = (i == code.size() - 1);
                    beat.bad = 1'b0;
                    pending_bytes = {pending_bytes, beat};
                end
            end else begin
                beat.code = 8'h00;
                beat.last = 1'b1;
                beat.bad = 1'b1;
                pending_bytes = {pending_bytes, beat};
            end
            burst_left--;
            @(negedge clk);
        end
        req_ch.valid = 1'b0;

        while (pending_bytes.size() != 0)
            @(posedge clk);
        // Anything the encoder still sends after this point is unexpected.
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Encoded %0d requests, %0d of them call wrappers, into %0d code bytes.",
                 n_requests, n_calls, n_bytes);
        $display("%0d requests were rejected; %0d mismatches were found.",
                 n_rejected, n_mismatches);
        if (n_mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

`default_nettype wire
